FILE: rtl/brf_pkg.sv
`timescale 1ns / 1ps

package brf_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int MAX_BURST   = 64;
  localparam int CAP_RESET   = 1024;

  localparam int CNT_W  = 11;
  localparam int BYTE_W = 8;
  localparam int REQ_W  = 7;
  localparam int OVF_W  = 16;

  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_EXTRACT  = 1'b1;
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // one result slot as it enters the output pipe
  typedef struct packed {
    logic              kind;
    logic              use_mem;
    logic [CNT_W-1:0]  acc;
    logic              last;
    logic [CNT_W-1:0]  dcount;
    logic [CNT_W-1:0]  fcount;
    logic [OVF_W-1:0]  ovf;
  } slot_t;

  // output pipe status seen by the controller
  typedef struct packed {
    logic can_issue;
    logic idle;
  } pipe_stat_t;

endpackage

FILE: rtl/brf_if.sv
`timescale 1ns / 1ps

interface brf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [brf_pkg::BYTE_W-1:0]   data_byte;
  logic                         first_byte;
  logic [brf_pkg::CNT_W-1:0]    block_length;
  logic [brf_pkg::REQ_W-1:0]    request_length;

  modport source (output valid, opcode, data_byte, first_byte, block_length,
                  request_length, input ready);
  modport sink (input valid, opcode, data_byte, first_byte, block_length,
                request_length, output ready);
endinterface

interface brf_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [brf_pkg::BYTE_W-1:0]   out_byte;
  logic [brf_pkg::CNT_W-1:0]    accepted_length;
  logic                         last_of_run;
  logic [brf_pkg::CNT_W-1:0]    data_count;
  logic [brf_pkg::CNT_W-1:0]    free_count;
  logic [brf_pkg::OVF_W-1:0]    overflow_count;

  modport source (output valid, kind, out_byte, accepted_length, last_of_run,
                  data_count, free_count, overflow_count, input ready);
  modport sink (input valid, kind, out_byte, accepted_length, last_of_run,
                data_count, free_count, overflow_count, output ready);
endinterface

interface brf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [brf_pkg::CNT_W-1:0]    capacity;

  modport source (output valid, capacity, input ready);
  modport sink (input valid, capacity, output ready);
endinterface

FILE: rtl/brf_ram.sv
`timescale 1ns / 1ps

module brf_ram #(
  parameter int DEPTH = brf_pkg::STORE_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [brf_pkg::BYTE_W-1:0]  wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [brf_pkg::BYTE_W-1:0]  rdata
);

  logic [brf_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/brf_ctrl.sv
`timescale 1ns / 1ps

module brf_ctrl #(
  parameter int STORE_DEPTH = brf_pkg::STORE_DEPTH,
  parameter int MAX_BURST   = brf_pkg::MAX_BURST,
  localparam int AW = $clog2(STORE_DEPTH),
  localparam int CW = brf_pkg::CNT_W
) (
  input  logic                        clk,
  input  logic                        rst,
  brf_in_if.sink                      item,
  brf_cfg_if.sink                     cfg,
  input  brf_pkg::pipe_stat_t         pipe,
  output logic                        issue,
  output brf_pkg::slot_t              slot,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [brf_pkg::BYTE_W-1:0]  mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  output logic [CW-1:0]               cap_eff
);

  localparam int WW = ((AW > CW) ? AW : CW) + 1;
  localparam int BW = $clog2(MAX_BURST + 1);
  localparam int RW = brf_pkg::REQ_W;
  localparam int OW = brf_pkg::OVF_W;
  localparam int CAP_RST_I = (brf_pkg::CAP_RESET > STORE_DEPTH) ? STORE_DEPTH
                                                                 : brf_pkg::CAP_RESET;
  localparam logic [CW-1:0] CAP_RST = CW'(CAP_RST_I);
  localparam logic [WW-1:0] DEPTH_W = WW'(STORE_DEPTH);
  localparam logic [RW-1:0] MAXB = RW'(MAX_BURST);
  localparam logic [OW-1:0] OVF_MAX = '1;

  logic [AW-1:0] wr_idx, wr_idx_next;
  logic [AW-1:0] rd_idx, rd_idx_next;
  logic [CW-1:0] committed, committed_next;
  logic [CW-1:0] pending, pending_next;
  logic [CW-1:0] blk_rem, blk_rem_next;
  logic          blk_rej, blk_rej_next;
  logic [OW-1:0] ovf_total, ovf_next;
  logic [BW-1:0] burst_left, burst_left_next;
  logic [AW-1:0] burst_addr, burst_addr_next;
  logic [BW-1:0] burst_acc, burst_acc_next;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a,
                                             input logic [CW-1:0] c);
    logic [WW-1:0] s;
    s = WW'(a) + WW'(1);
    wrap_inc = (s >= WW'(c)) ? '0 : AW'(s);
  endfunction

  logic busy, cfg_wr, accept, ins_acc, ext_acc;
  logic [CW-1:0] cap_new;
  logic [WW-1:0] cap_raw_w;

  assign busy       = (burst_left != '0);
  assign cfg.ready  = pipe.idle && !busy;
  assign cfg_wr     = cfg.valid && cfg.ready;
  assign item.ready = !busy && pipe.can_issue && !cfg.valid;
  assign accept     = item.valid && item.ready;
  assign ins_acc    = accept && (item.opcode == brf_pkg::OP_INSERT);
  assign ext_acc    = accept && (item.opcode == brf_pkg::OP_EXTRACT);

  assign cap_raw_w = WW'(cfg.capacity);
  assign cap_new   = (cfg.capacity == '0) ? CW'(1) :
                     (cap_raw_w > DEPTH_W) ? CW'(DEPTH_W) : cfg.capacity;

  // insert: abandon of an open block, then fit check of a new one
  logic          abandon, rej_new, live;
  logic [CW-1:0] pend_mod, pend_a, blen_e, free_a;
  logic [WW-1:0] wi_back;
  logic [AW-1:0] wi_a;
  logic          rej_c;
  logic [CW-1:0] pend_c, rem_c, rem_d;
  logic [OW-1:0] ovf_c;

  assign pend_mod = (pending == cap_eff) ? '0 : pending;
  assign abandon  = item.first_byte && (blk_rem != '0) && !blk_rej;
  assign wi_back  = (WW'(wr_idx) >= WW'(pend_mod)) ? WW'(wr_idx) - WW'(pend_mod)
                  : WW'(wr_idx) + WW'(cap_eff) - WW'(pend_mod);
  assign wi_a     = abandon ? AW'(wi_back) : wr_idx;
  assign pend_a   = abandon ? '0 : pending;
  assign blen_e   = (item.block_length == '0) ? CW'(1) : item.block_length;
  assign free_a   = cap_eff - committed - pend_a;
  assign rej_new  = (blen_e > free_a);
  assign live     = item.first_byte || (blk_rem != '0);

  assign rej_c  = item.first_byte ? rej_new : blk_rej;
  assign pend_c = item.first_byte ? (rej_new ? pend_a : blen_e) : pending;
  assign rem_c  = item.first_byte ? blen_e : blk_rem;
  assign rem_d  = rem_c - CW'(1);
  assign ovf_c  = (item.first_byte && rej_new && (ovf_total != OVF_MAX))
                  ? ovf_total + OW'(1) : ovf_total;

  // extract: clamp the request to the burst limit and the committed count
  logic [RW-1:0] req_c;
  logic [CW-1:0] n_cnt;
  logic [WW-1:0] rd_sum;

  assign req_c  = (item.request_length > MAXB) ? MAXB : item.request_length;
  assign n_cnt  = (CW'(req_c) < committed) ? CW'(req_c) : committed;
  assign rd_sum = WW'(rd_idx) + WW'(n_cnt);

  assign mem_wdata = item.data_byte;

  logic          s_kind, s_mem, s_last;
  logic [CW-1:0] s_acc;

  always_comb begin
    wr_idx_next     = wr_idx;
    rd_idx_next     = rd_idx;
    committed_next  = committed;
    pending_next    = pending;
    blk_rem_next    = blk_rem;
    blk_rej_next    = blk_rej;
    ovf_next        = ovf_total;
    burst_left_next = burst_left;
    burst_addr_next = burst_addr;
    burst_acc_next  = burst_acc;
    issue     = 1'b0;
    s_kind    = brf_pkg::KIND_STATUS;
    s_mem     = 1'b0;
    s_acc     = '0;
    s_last    = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = wi_a;
    mem_re    = 1'b0;
    mem_raddr = rd_idx;
    if (busy) begin
      if (pipe.can_issue) begin
        issue           = 1'b1;
        s_kind          = brf_pkg::KIND_DATA;
        s_mem           = 1'b1;
        s_acc           = CW'(burst_acc);
        s_last          = (burst_left == BW'(1));
        mem_re          = 1'b1;
        mem_raddr       = burst_addr;
        burst_left_next = burst_left - BW'(1);
        burst_addr_next = wrap_inc(burst_addr, cap_eff);
      end
    end else if (ins_acc) begin
      if (live) begin
        mem_we       = !rej_c;
        wr_idx_next  = rej_c ? wi_a : wrap_inc(wi_a, cap_eff);
        blk_rem_next = rem_d;
        ovf_next     = ovf_c;
        if (rem_d == '0) begin
          // block done: one status word
          issue        = 1'b1;
          s_acc        = rej_c ? '0 : pend_c;
          blk_rej_next = 1'b0;
          if (rej_c) begin
            pending_next = pend_c;
          end else begin
            committed_next = committed + pend_c;
            pending_next   = '0;
          end
        end else begin
          pending_next = pend_c;
          blk_rej_next = rej_c;
        end
      end
    end else if (ext_acc) begin
      issue  = 1'b1;
      s_kind = brf_pkg::KIND_DATA;
      if (n_cnt != '0) begin
        s_mem           = 1'b1;
        s_acc           = n_cnt;
        s_last          = (n_cnt == CW'(1));
        mem_re          = 1'b1;
        mem_raddr       = rd_idx;
        committed_next  = committed - n_cnt;
        rd_idx_next     = (rd_sum >= WW'(cap_eff)) ? AW'(rd_sum - WW'(cap_eff))
                                                   : AW'(rd_sum);
        burst_left_next = BW'(n_cnt) - BW'(1);
        burst_addr_next = wrap_inc(rd_idx, cap_eff);
        burst_acc_next  = BW'(n_cnt);
      end
    end
    slot.kind    = s_kind;
    slot.use_mem = s_mem;
    slot.acc     = s_acc;
    slot.last    = s_last;
    slot.dcount  = committed_next;
    slot.fcount  = cap_eff - committed_next - pending_next;
    slot.ovf     = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_eff    <= CAP_RST;
      wr_idx     <= '0;
      rd_idx     <= '0;
      committed  <= '0;
      pending    <= '0;
      blk_rem    <= '0;
      blk_rej    <= 1'b0;
      ovf_total  <= '0;
      burst_left <= '0;
      burst_addr <= '0;
      burst_acc  <= '0;
    end else if (cfg_wr) begin
      cap_eff    <= cap_new;
      wr_idx     <= '0;
      rd_idx     <= '0;
      committed  <= '0;
      pending    <= '0;
      blk_rem    <= '0;
      blk_rej    <= 1'b0;
      ovf_total  <= '0;
      burst_left <= '0;
      burst_addr <= '0;
      burst_acc  <= '0;
    end else begin
      wr_idx     <= wr_idx_next;
      rd_idx     <= rd_idx_next;
      committed  <= committed_next;
      pending    <= pending_next;
      blk_rem    <= blk_rem_next;
      blk_rej    <= blk_rej_next;
      ovf_total  <= ovf_next;
      burst_left <= burst_left_next;
      burst_addr <= burst_addr_next;
      burst_acc  <= burst_acc_next;
    end
  end

endmodule

FILE: rtl/brf_outpipe.sv
`timescale 1ns / 1ps

module brf_outpipe (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        issue,
  input  brf_pkg::slot_t              slot,
  input  logic [brf_pkg::BYTE_W-1:0]  rdata,
  output brf_pkg::pipe_stat_t         pipe,
  brf_out_if.source                   result
);

  // stage 1 lines up with the memory read data, stage 2 is the output register
  logic           s1_valid, s2_valid, s1_move, s2_open;
  brf_pkg::slot_t s1;
  logic                         o_kind, o_last;
  logic [brf_pkg::BYTE_W-1:0]   o_byte;
  logic [brf_pkg::CNT_W-1:0]    o_acc, o_dcount, o_fcount;
  logic [brf_pkg::OVF_W-1:0]    o_ovf;

  assign s2_open        = !s2_valid || result.ready;
  assign s1_move        = s1_valid && s2_open;
  assign pipe.can_issue = !s1_valid || s1_move;
  assign pipe.idle      = !s1_valid && !s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (pipe.can_issue) begin
        s1_valid <= issue;
      end
      if (s2_open) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.can_issue && issue) begin
      s1 <= slot;
    end
    if (s1_move) begin
      o_kind   <= s1.kind;
      o_byte   <= s1.use_mem ? rdata : '0;
      o_acc    <= s1.acc;
      o_last   <= s1.last;
      o_dcount <= s1.dcount;
      o_fcount <= s1.fcount;
      o_ovf    <= s1.ovf;
    end
  end

  assign result.valid           = s2_valid;
  assign result.kind            = o_kind;
  assign result.out_byte        = o_byte;
  assign result.accepted_length = o_acc;
  assign result.last_of_run     = o_last;
  assign result.data_count      = o_dcount;
  assign result.free_count      = o_fcount;
  assign result.overflow_count  = o_ovf;

endmodule

FILE: rtl/byte_ring_fifo_block_access.sv
// byte ring buffer with block insert and burst extract over one byte store
// latency: a result word passes the read-data stage and the output register to the port
// throughput: one insert byte per cycle when no burst runs and the output can move;
//   extract bytes leave the single read port of the store one per unstalled cycle
// reset (synchronous): indices, counts, block progress and overflow counter clear,
//   capacity returns to 1024 (clamped to the store depth); store contents are kept
`timescale 1ns / 1ps

module byte_ring_fifo_block_access #(
  parameter int STORE_DEPTH = brf_pkg::STORE_DEPTH,
  parameter int MAX_BURST   = brf_pkg::MAX_BURST
) (
  input logic        clk,
  input logic        rst,
  brf_in_if.sink     item,
  brf_out_if.source  result,
  brf_cfg_if.sink    cfg
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = brf_pkg::CNT_W;

  // controller to output pipe
  logic                        issue;
  brf_pkg::slot_t              slot;
  brf_pkg::pipe_stat_t         pipe;

  // byte store ports
  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [brf_pkg::BYTE_W-1:0]  mem_wdata, mem_rdata;

  // ring wrap point after clamping, used by the checks below
  logic [CW-1:0]               cap_eff;

  // ring state, block tracking and the burst sequencer; a capacity word is taken
  // only once the output pipe has drained and no burst is running
  brf_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_BURST   (MAX_BURST)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg       (cfg),
    .pipe      (pipe),
    .issue     (issue),
    .slot      (slot),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .cap_eff   (cap_eff)
  );

  // the store: inserts go to the write index, extract reads one per unstalled cycle;
  // only committed bytes are read, always written in an earlier cycle
  brf_ram #(
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // read-data stage plus output register, so a waiting word does not stop input
  brf_outpipe u_outpipe (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue),
    .slot   (slot),
    .rdata  (mem_rdata),
    .pipe   (pipe),
    .result (result)
  );

  // committed plus free never exceeds the ring size
  a_counts_fit: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ({1'b0, result.data_count} + {1'b0, result.free_count})
                     <= {1'b0, cap_eff})
    else $error("data and free counts exceed capacity");

  // a burst keeps the output busy until its last byte
  a_burst_gapless: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && (result.kind == brf_pkg::KIND_DATA)
    && !result.last_of_run |=> result.valid)
    else $error("gap inside an extract burst");

  // capacity is never changed while a word is still waiting
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready |-> !result.valid)
    else $error("capacity write with output pending");

endmodule
